### sv/wus_pkg.sv
// ----------------------------------------------------------------------------
// wus_pkg
// Shared types, widths and constants for the water use statistics unit.
// ----------------------------------------------------------------------------
package wus_pkg;

  localparam int RING_DEPTH_DEF = 8;

  localparam int SUM_W   = 32;
  localparam int VAL_W   = 16;
  localparam int CMD_W   = 2;
  localparam int AMT_W   = 16;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 16;
  localparam int OUT_W   = 2 * SUM_W + 5 * VAL_W;

  // command codes carried in tuser
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MINUTE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HOUR   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DAY    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_DAILY_LIMIT = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FLOW_LIMIT  = 2'd1;

  localparam logic [VAL_W-1:0] DAILY_LIMIT_RST = 16'd18;
  localparam logic [VAL_W-1:0] FLOW_LIMIT_RST  = 16'd6;
  localparam logic [VAL_W-1:0] VAL_MAX         = 16'hFFFF;

  // saturate a 32-bit count to 16 bits
  function automatic logic [VAL_W-1:0] sat16(input logic [SUM_W-1:0] v);
    sat16 = (|v[SUM_W-1:VAL_W]) ? VAL_MAX : v[VAL_W-1:0];
  endfunction

  // growth of the running sum since a snapshot, 0 if it did not grow
  function automatic logic [VAL_W-1:0] grow(input logic [SUM_W-1:0] sum,
                                            input logic [SUM_W-1:0] snap);
    grow = (sum > snap) ? sat16(sum - snap) : '0;
  endfunction

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

### sv/wus_div.sv
// ----------------------------------------------------------------------------
// wus_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wus_div #(
  parameter int DW = 32,
  parameter int VW = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DW-1:0]       dividend,
  input  logic [VW-1:0]       divisor,
  output logic                done,
  output logic [DW-1:0]       quotient
);

  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic          busy;
  logic [CW-1:0] count;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] q;
  logic [VW:0]   trial;
  logic          ge;

  assign trial    = {rem, q[DW-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
      q   <= {q[DW-2:0], ge};
    end
  end

endmodule

### sv/water_use_statistics.sv
// ----------------------------------------------------------------------------
// water_use_statistics
// Water meter statistics: totals, flow rate, hourly/daily use, average and
// vacation day count.
// ----------------------------------------------------------------------------
// Input words (s_*): tuser carries the command (add volume, minute, hour or
// day tick), tdata the litres to add. Each accepted word yields exactly one
// result word on m_*, showing the statistics after the command.
// Configuration (cfg_*): index 0 daily vacation limit, index 1 flow limit;
// always ready, other indexes ignored. Write only while the unit is idle.
// Add, minute and hour words pass through the update state to the result
// register. A day tick does the ring write and read, then the serial
// divider makes one quotient bit per cycle (32 bits) to divide the ring
// difference by the day count, then the vacation update follows.
// The first day tick skips the divide.
// One word is worked on at a time; s_tready is low while it is in progress.
// A finished result waits in the output register; the next word may be
// accepted meanwhile, but its result holds until m_tready takes the old one.
// Reset clears all totals, snapshots, counters and the day count and loads
// the default limits; ring entries are only read after they are written.
// ----------------------------------------------------------------------------
module water_use_statistics #(
  parameter int RING_DEPTH = wus_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [wus_pkg::AMT_W-1:0]   s_tdata,   // amount
  input  logic [wus_pkg::CMD_W-1:0]   s_tuser,   // cmd
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // total_use, flow_rate, last_hour_use, yesterday_use, avg_daily_use,
  // vacation_days, regen_estimate
  output logic [wus_pkg::OUT_W-1:0]   m_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wus_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [wus_pkg::CFG_DW-1:0]  cfg_data
);

  localparam int IW  = $clog2(RING_DEPTH);
  localparam int SW  = wus_pkg::SUM_W;
  localparam int VW  = wus_pkg::VAL_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
  localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(RING_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DAY  = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_VAC  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    state;
  logic [VW-1:0] daily_limit;
  logic [VW-1:0] flow_limit;

  logic [SW-1:0] total_litres, running_sum, regen_litres;
  logic [SW-1:0] minute_snap, hour_snap, day_snap;
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] days_seen;
  logic [VW-1:0] rate_value, hour_value, day_value, average_value, low_use_days;

  logic [SW-1:0] ring [RING_DEPTH];
  logic [SW-1:0] rd_data;
  logic [IW-1:0] old_idx;
  logic          ring_op;

  wus_pkg::div_ctl_t div_ctl;
  logic [SW-1:0]     quotient;

  logic [wus_pkg::CMD_W-1:0] cmd;
  logic [wus_pkg::AMT_W-1:0] amount;

  logic accept;
  logic out_free;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign ring_op   = (state == S_DAY);

  // slot days_seen ticks behind the write slot
  always_comb begin
    if ({1'b0, wr_idx} >= {1'b0, days_seen}) begin
      old_idx = wr_idx - days_seen;
    end else begin
      old_idx = IW'({1'b0, wr_idx} + DEPTH_X - {1'b0, days_seen});
    end
  end

  always_ff @(posedge clk) begin
    if (ring_op) begin
      ring[wr_idx] <= running_sum;
      rd_data      <= ring[old_idx];
    end
  end

  assign div_ctl.start = (state == S_READ);

  wus_div #(
    .DW (SW),
    .VW (IW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_ctl.start),
    .dividend (running_sum - rd_data),
    .divisor  (days_seen),
    .done     (div_ctl.done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      daily_limit <= wus_pkg::DAILY_LIMIT_RST;
      flow_limit  <= wus_pkg::FLOW_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == wus_pkg::REG_DAILY_LIMIT) begin
        daily_limit <= cfg_data;
      end else if (cfg_index == wus_pkg::REG_FLOW_LIMIT) begin
        flow_limit <= cfg_data;
      end
    end
  end

  // hold the command and amount for the later steps of every word
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= s_tuser;
      amount <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      total_litres  <= '0;
      running_sum   <= '0;
      regen_litres  <= '0;
      minute_snap   <= '0;
      hour_snap     <= '0;
      day_snap      <= '0;
      wr_idx        <= '0;
      days_seen     <= '0;
      rate_value    <= '0;
      hour_value    <= '0;
      day_value     <= '0;
      average_value <= '0;
      low_use_days  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (s_tuser == wus_pkg::CMD_DAY) ? S_DAY : S_VAC;
          end
        end
        S_DAY: begin
          day_value <= wus_pkg::grow(running_sum, day_snap);
          day_snap  <= running_sum;
          wr_idx    <= (wr_idx == LAST_IDX) ? '0 : wr_idx + 1'b1;
          if (days_seen == '0) begin
            days_seen <= IW'(1);
            state     <= S_VAC;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_ctl.done) begin
            average_value <= wus_pkg::sat16(quotient);
            if (days_seen < LAST_IDX) begin
              days_seen <= days_seen + 1'b1;
            end
            state <= S_VAC;
          end
        end
        S_VAC: begin
          unique case (cmd)
            wus_pkg::CMD_ADD: begin
              total_litres <= total_litres + SW'(amount);
              running_sum  <= running_sum + SW'(amount);
              regen_litres <= regen_litres + SW'(amount);
            end
            wus_pkg::CMD_MINUTE: begin
              rate_value  <= wus_pkg::grow(running_sum, minute_snap);
              minute_snap <= running_sum;
            end
            wus_pkg::CMD_HOUR: begin
              hour_value <= wus_pkg::grow(running_sum, hour_snap);
              hour_snap  <= running_sum;
            end
            wus_pkg::CMD_DAY: begin
              if (day_value >= daily_limit || rate_value >= flow_limit) begin
                low_use_days <= '0;
              end else if (low_use_days != wus_pkg::VAL_MAX) begin
                low_use_days <= low_use_days + 1'b1;
              end
            end
            default: begin
            end
          endcase
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the previous result word has gone
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {regen_litres + SW'(average_value), low_use_days, average_value,
                  day_value, hour_value, rate_value, total_litres};
    end
  end

endmodule
